[sv/mlfq_pkg.sv]
package mlfq_pkg;

    typedef struct packed {
        logic        req_type;
        logic [4:0]  proc_id;
        logic [15:0] burst_time;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  ran_id;
        logic [1:0]  ran_level;
        logic        finished;
        logic [15:0] finish_time;
        logic [15:0] elapsed_time;
        logic [15:0] total_wait;
    } t_out_item;

    // commands from controller to datapath
    typedef struct packed {
        logic latch_in;
        logic admit;
        logic tick_start;
        logic scan;
        logic push;
    } t_ctrl_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic req_tick;
        logic no_runnable;
        logic scan_last;
        logic out_free;
    } t_ctrl_sts;

    localparam logic       REQ_ADMIT = 1'b0;
    localparam logic       REQ_TICK  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_REJECT    = 2'd1;
    localparam logic [1:0] ST_IDLE_TICK = 2'd2;

    localparam logic [1:0] LVL_NONE  = 2'd0;
    localparam logic [1:0] LVL_ONE   = 2'd1;
    localparam logic [1:0] LVL_TWO   = 2'd2;
    localparam logic [1:0] LVL_THREE = 2'd3;

    localparam logic [1:0] CFG_QUANTUM_ONE = 2'd0;
    localparam logic [1:0] CFG_QUANTUM_TWO = 2'd1;
    localparam logic [1:0] CFG_AGING_LIMIT = 2'd2;

    localparam logic [7:0] RST_QUANTUM_ONE = 8'd2;
    localparam logic [7:0] RST_QUANTUM_TWO = 8'd4;
    localparam logic [7:0] RST_AGING_LIMIT = 8'd10;

    localparam int POS_W = 5;
    localparam int CNT_W = 6;

endpackage

[sv/mlfq_scheduler_with_aging_top.sv]
// Sequence: an item is latched and decoded; an admit is then applied, while a tick
// starts and, unless no level holds a process, runs the slot scan that updates waiting,
// aging and queue positions one slot per cycle. The result then moves into the output
// register once it is free. Throughput: one item at a time; the next item is taken
// only after the result registers.
// Reset: synchronous active-low i_rst_n empties all queues, zeroes clock and wait sum,
// and loads quantum 2 / 4 and aging limit 10.
module mlfq_scheduler_with_aging_top import mlfq_pkg::*; #(
    parameter int MAX_PROCS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;
    logic      busy;

    // Controller sequences admit, tick start, slot scan and result hand-off.
    mlfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    // Datapath holds per-slot state, queue counts and the output register.
    mlfq_datapath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // Take a new item only between items; the output register lets the
    // previous result wait while the next item runs.
    assign o_in_stall  = busy;
    assign o_cfg_ready = 1'b1;

endmodule

[sv/mlfq_ctrl.sv]
module mlfq_ctrl import mlfq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd,
    output logic      o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADMIT,
        S_TSTART,
        S_SCAN,
        S_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_TSTART;
                end
            end
            S_TSTART: begin
                if (i_sts.req_tick == REQ_ADMIT) begin
                    n_state = S_ADMIT;
                end else begin
                    o_cmd.tick_start = 1'b1;
                    n_state = i_sts.no_runnable ? S_OUT : S_SCAN;
                end
            end
            S_ADMIT: begin
                o_cmd.admit = 1'b1;
                n_state     = S_OUT;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[sv/mlfq_datapath.sv]
module mlfq_datapath import mlfq_pkg::*; #(
    parameter int MAX_PROCS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  logic      i_out_stall,
    input  logic      i_cfg_wr,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  t_ctrl_cmd i_cmd,
    output t_ctrl_sts o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int IW = $clog2(MAX_PROCS);

    t_in_item         r_item;
    logic [7:0]       r_q1, r_q2, r_age;
    logic [1:0]       r_lvl  [MAX_PROCS];
    logic [1:0]       n_lvl  [MAX_PROCS];
    logic [POS_W-1:0] r_pos  [MAX_PROCS];
    logic [POS_W-1:0] n_pos  [MAX_PROCS];
    logic [15:0]      r_rem  [MAX_PROCS];
    logic [15:0]      n_rem  [MAX_PROCS];
    logic [7:0]       r_wal  [MAX_PROCS];
    logic [7:0]       n_wal  [MAX_PROCS];
    logic [CNT_W-1:0] r_qcnt [3];
    logic [CNT_W-1:0] n_qcnt [3];
    logic [7:0]       r_qleft, n_qleft;
    logic [IW-1:0]    r_last, n_last;
    logic             r_last_vld, n_last_vld;
    logic [15:0]      r_clock, n_clock;
    logic [15:0]      r_wsum, n_wsum;
    logic [1:0]       r_e, n_e;
    logic             r_found, n_found;
    logic [IW-1:0]    r_idx, n_idx;
    t_out_item        r_res, n_res;
    t_out_item        r_out;
    logic             r_out_vld;

    logic             lv_en, jn_en;
    logic [1:0]       jn_lvl, old_l;
    logic [POS_W-1:0] old_p;
    logic [IW-1:0]    slot;
    logic [1:0]       s_lvl;
    logic [POS_W-1:0] s_pos;
    logic [15:0]      s_rem;
    logic [7:0]       s_wal;
    logic [7:0]       ql, ql_n, wal_n, limit;
    logic [15:0]      rem_n;
    logic             id_ok;

    assign slot  = i_cmd.admit ? IW'(r_item.proc_id) : r_idx;
    assign s_lvl = r_lvl[slot];
    assign s_pos = r_pos[slot];
    assign s_rem = r_rem[slot];
    assign s_wal = r_wal[slot];
    assign id_ok = (32'(r_item.proc_id) < 32'(MAX_PROCS));
    assign limit = (r_age == 8'd0) ? 8'd1 : r_age;

    always_comb begin
        n_lvl = r_lvl;  n_pos = r_pos;  n_rem = r_rem;  n_wal = r_wal;
        n_qcnt = r_qcnt;
        n_qleft = r_qleft; n_last = r_last; n_last_vld = r_last_vld;
        n_clock = r_clock; n_wsum = r_wsum; n_e = r_e; n_found = r_found;
        n_idx = r_idx; n_res = r_res;
        lv_en = 1'b0; jn_en = 1'b0; jn_lvl = LVL_ONE;
        ql = 8'd0; ql_n = 8'd0; wal_n = 8'd0; rem_n = 16'd0;
        old_l = LVL_NONE; old_p = '0;

        if (i_cmd.admit) begin
            n_res = '0;
            if (!id_ok || s_lvl != LVL_NONE) begin
                n_res.status = ST_REJECT;
            end else begin
                n_res.status = ST_OK;
                n_rem[slot]  = (r_item.burst_time == 16'd0) ? 16'd1 : r_item.burst_time;
                jn_en  = 1'b1;
                jn_lvl = LVL_ONE;
            end
        end

        if (i_cmd.tick_start) begin
            n_clock = (r_clock == 16'hFFFF) ? r_clock : r_clock + 16'd1;
            if (r_qcnt[0] != '0)      n_e = LVL_ONE;
            else if (r_qcnt[1] != '0) n_e = LVL_TWO;
            else if (r_qcnt[2] != '0) n_e = LVL_THREE;
            else                      n_e = LVL_NONE;
            n_idx   = '0;
            n_found = 1'b0;
            n_res   = '0;
            n_res.status = (n_e == LVL_NONE) ? ST_IDLE_TICK : ST_OK;
        end

        if (i_cmd.scan) begin
            n_idx = r_idx + IW'(1);
            if (!r_found && s_lvl == r_e && s_pos == '0) begin
                // serve the head of the top non-empty level
                if (!r_last_vld || r_last != r_idx) begin
                    ql = (r_e == LVL_ONE) ? r_q1 : ((r_e == LVL_TWO) ? r_q2 : 8'd0);
                end else begin
                    ql = r_qleft;
                end
                rem_n = (s_rem != 16'd0) ? s_rem - 16'd1 : s_rem;
                ql_n  = (r_e != LVL_THREE && ql != 8'd0) ? ql - 8'd1 : ql;
                n_rem[slot]   = rem_n;
                n_qleft       = ql_n;
                n_found       = 1'b1;
                n_last        = r_idx;
                n_last_vld    = 1'b1;
                n_res.ran_id    = 5'(r_idx);
                n_res.ran_level = r_e;
                if (rem_n == 16'd0) begin
                    lv_en = 1'b1;
                    n_wal[slot] = 8'd0;
                    n_res.finished    = 1'b1;
                    n_res.finish_time = r_clock;
                    n_last_vld = 1'b0;
                end else if (r_e != LVL_THREE && ql_n == 8'd0) begin
                    lv_en  = 1'b1;
                    jn_en  = 1'b1;
                    jn_lvl = r_e + 2'd1;
                    n_last_vld = 1'b0;
                end
            end else if (s_lvl != LVL_NONE) begin
                wal_n  = (s_wal == 8'hFF) ? s_wal : s_wal + 8'd1;
                n_wsum = (r_wsum == 16'hFFFF) ? r_wsum : r_wsum + 16'd1;
                n_wal[slot] = wal_n;
                if (s_lvl > LVL_ONE && wal_n >= limit) begin
                    lv_en  = 1'b1;
                    jn_en  = 1'b1;
                    jn_lvl = s_lvl - 2'd1;
                end
            end
        end

        // leave: close the gap behind the slot
        if (lv_en) begin
            old_l = r_lvl[slot];
            old_p = r_pos[slot];
            if (old_l != LVL_NONE) begin
                for (int k = 0; k < MAX_PROCS; k++) begin
                    if (IW'(k) != slot && r_lvl[k] == old_l && r_pos[k] > old_p) begin
                        n_pos[k] = r_pos[k] - POS_W'(1);
                    end
                end
                if (r_qcnt[old_l - 2'd1] != '0) begin
                    n_qcnt[old_l - 2'd1] = r_qcnt[old_l - 2'd1] - CNT_W'(1);
                end
                n_lvl[slot] = LVL_NONE;
                n_pos[slot] = '0;
            end
        end

        // join: append at the tail of the new level
        if (jn_en) begin
            n_lvl[slot] = jn_lvl;
            n_pos[slot] = n_qcnt[jn_lvl - 2'd1][POS_W-1:0];
            n_qcnt[jn_lvl - 2'd1] = n_qcnt[jn_lvl - 2'd1] + CNT_W'(1);
            n_wal[slot] = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1       <= RST_QUANTUM_ONE;
            r_q2       <= RST_QUANTUM_TWO;
            r_age      <= RST_AGING_LIMIT;
            for (int k = 0; k < MAX_PROCS; k++) begin
                r_lvl[k] <= LVL_NONE;
                r_pos[k] <= '0;
            end
            for (int k = 0; k < 3; k++) r_qcnt[k] <= '0;
            r_qleft    <= 8'd0;
            r_last     <= '0;
            r_last_vld <= 1'b0;
            r_clock    <= 16'd0;
            r_wsum     <= 16'd0;
            r_e        <= LVL_NONE;
            r_found    <= 1'b0;
            r_idx      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    CFG_QUANTUM_ONE: r_q1  <= i_cfg_data;
                    CFG_QUANTUM_TWO: r_q2  <= i_cfg_data;
                    CFG_AGING_LIMIT: r_age <= i_cfg_data;
                    default: ;
                endcase
            end
            r_lvl      <= n_lvl;
            r_pos      <= n_pos;
            r_qcnt     <= n_qcnt;
            r_qleft    <= n_qleft;
            r_last     <= n_last;
            r_last_vld <= n_last_vld;
            r_clock    <= n_clock;
            r_wsum     <= n_wsum;
            r_e        <= n_e;
            r_found    <= n_found;
            r_idx      <= n_idx;
            if (i_cmd.push)            r_out_vld <= 1'b1;
            else if (!i_out_stall)     r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_wal <= n_wal;
        r_res <= n_res;
        if (i_cmd.latch_in) r_item <= i_in_item;
        if (i_cmd.push) begin
            r_out <= '{status:       r_res.status,
                       ran_id:       r_res.ran_id,
                       ran_level:    r_res.ran_level,
                       finished:     r_res.finished,
                       finish_time:  r_res.finish_time,
                       elapsed_time: r_clock,
                       total_wait:   r_wsum};
        end
    end

    assign o_sts.req_tick    = r_item.req_type;
    assign o_sts.no_runnable = (r_qcnt[0] == '0) && (r_qcnt[1] == '0) && (r_qcnt[2] == '0);
    assign o_sts.scan_last   = (r_idx == IW'(MAX_PROCS - 1));
    assign o_sts.out_free    = !r_out_vld || !i_out_stall;
    assign o_out_valid       = r_out_vld;
    assign o_out_item        = r_out;

endmodule
